// File: hdl/csp_pkg.sv
// csp_pkg: item types and status codes of the counting semaphore block
// no dependencies; used by the top level and its testbench
package csp_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] task_id;
		logic [7:0] priority_req;
		logic [7:0] trigger;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] woken_task;
		logic [7:0] woken_trigger;
		logic [7:0] free_count;
	} out_item_t;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [2:0] ST_GRANTED      = 3'd0;
	localparam logic [2:0] ST_QUEUED       = 3'd1;
	localparam logic [2:0] ST_WAITER_GRANT = 3'd2;
	localparam logic [2:0] ST_RETURNED     = 3'd3;
	localparam logic [2:0] ST_POOL_FULL    = 3'd4;
	localparam logic [2:0] ST_BAD_RELEASE  = 3'd5;

	localparam logic REG_MAX_RESOURCES  = 1'b0;
	localparam logic REG_ENTRIES_IN_USE = 1'b1;

endpackage

// File: hdl/csp_ram.sv
// csp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module csp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/counting_semaphore_priority_queue.sv
// counting_semaphore_priority_queue: top level, sequencer and list storage
// depends on csp_pkg and csp_ram
//
// Counting semaphore with a pool of POOL_ENTRIES entries shared by a holder list and a wait
// list, both sorted by falling priority with equal priorities in arrival order. One item is
// worked at a time: in_stall stays high from acceptance until the result is loaded into the
// output register. A request, and a release that grants a waiter, each walk past entries
// of the target list during sorted insertion (up to POOL_ENTRIES - 1); the walk is set by
// the link RAM read port, one entry per cycle. Writing either register reinitializes all
// lists and the free count; do so only while the block is idle. No clearing pass is needed
// after reset.
module counting_semaphore_priority_queue #(
	parameter int POOL_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  csp_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output csp_pkg::out_item_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	import csp_pkg::*;

	localparam int AW = $clog2(POOL_ENTRIES);
	localparam int IW = $clog2(POOL_ENTRIES + 1);
	localparam int CW = (IW > 5) ? IW : 5;
	localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

	typedef struct packed {
		logic [7:0] task_id;
		logic [7:0] prio;
		logic [7:0] trigger;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_REQ0, S_REQ1, S_REL0, S_REL1, S_REL2, S_WALK, S_LINK, S_LINK2, S_FIN
	} state_t;

	state_t            state_q;
	logic [7:0]        max_q;
	logic [4:0]        entries_q;
	logic [IW-1:0]     holder_head_q, waiter_head_q, free_head_q;
	logic [7:0]        avail_q;
	logic [IW-1:0]     e_q, cur_q, prev_q;
	logic [7:0]        pr_q, task_q, trig_q;
	logic              sel_waiter_q;
	logic [2:0]        res_status_q;
	logic [7:0]        res_task_q, res_trig_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [POOL_ENTRIES-1:0] valid_q;
	logic              valid_s1;
	logic [AW-1:0]     rd_addr_s1;

	logic              cfg_wr;
	logic [4:0]        ent_src;
	logic [7:0]        max_src;
	logic [CW-1:0]     ent_ext, lim;
	logic [IW-1:0]     n_lim;
	logic [IW-1:0]     rd_ptr;
	logic [AW-1:0]     rd_addr;
	logic [IW-1:0]     next_ram_rd, next_dflt, next_rd, addr_plus1;
	logic              nwe;
	logic [AW-1:0]     nwaddr;
	logic [IW-1:0]     nwdata;
	logic              dwe;
	entry_t            dwdata, rec;
	logic              out_load;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? {27'd0, entries_q} : {24'd0, max_q};

	// a write takes effect at once on the list reinit
	assign ent_src = (cfg_wr && paddr[2] == REG_ENTRIES_IN_USE) ? pwdata[4:0] : entries_q;
	assign max_src = (cfg_wr && paddr[2] == REG_MAX_RESOURCES) ? pwdata[7:0] : max_q;
	assign ent_ext = CW'(ent_src);
	assign lim     = (ent_ext > CW'(POOL_ENTRIES)) ? CW'(POOL_ENTRIES) : ent_ext;
	assign n_lim   = IW'(lim);

	// unwritten link entries read as the initial chained free list
	assign addr_plus1 = IW'(rd_addr_s1) + IW'(1);
	assign next_dflt  = (addr_plus1 < n_lim) ? addr_plus1 : NIL;
	assign next_rd    = valid_s1 ? next_ram_rd : next_dflt;

	always_comb begin
		case (state_q)
			S_REQ0:  rd_ptr = free_head_q;
			S_REQ1:  rd_ptr = (avail_q != 8'd0) ? holder_head_q : waiter_head_q;
			S_REL0:  rd_ptr = holder_head_q;
			S_REL1:  rd_ptr = waiter_head_q;
			S_REL2:  rd_ptr = holder_head_q;
			S_WALK:  rd_ptr = next_rd;
			default: rd_ptr = free_head_q;
		endcase
	end
	assign rd_addr = rd_ptr[AW-1:0];

	always_comb begin
		nwe    = 1'b0;
		nwaddr = e_q[AW-1:0];
		nwdata = cur_q;
		case (state_q)
			S_REL1: begin
				nwe    = 1'b1;
				nwdata = free_head_q;
			end
			S_LINK: begin
				nwe = 1'b1;
			end
			S_LINK2: begin
				nwe    = 1'b1;
				nwaddr = prev_q[AW-1:0];
				nwdata = e_q;
			end
			default: nwe = 1'b0;
		endcase
	end

	assign dwe    = (state_q == S_REQ0) && (free_head_q != NIL);
	assign dwdata = '{task_id: task_q, prio: pr_q, trigger: trig_q};

	csp_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (nwe),
		.waddr (nwaddr),
		.wdata (nwdata),
		.raddr (rd_addr),
		.rdata (next_ram_rd)
	);

	csp_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (dwe),
		.waddr (free_head_q[AW-1:0]),
		.wdata (dwdata),
		.raddr (rd_addr),
		.rdata (rec)
	);

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_q         <= 8'd1;
			entries_q     <= 5'd16;
			holder_head_q <= NIL;
			waiter_head_q <= NIL;
			free_head_q   <= (POOL_ENTRIES > 0) ? IW'(0) : NIL;
			avail_q       <= 8'd1;
			valid_q       <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			valid_s1 <= valid_q[rd_addr];
			if (nwe) begin
				valid_q[nwaddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2] == REG_MAX_RESOURCES) begin
					max_q <= pwdata[7:0];
				end else begin
					entries_q <= pwdata[4:0];
				end
				holder_head_q <= NIL;
				waiter_head_q <= NIL;
				free_head_q   <= (n_lim != '0) ? IW'(0) : NIL;
				avail_q       <= max_src;
				valid_q       <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						task_q     <= in_data.task_id;
						pr_q       <= in_data.priority_req;
						trig_q     <= in_data.trigger;
						res_task_q <= 8'd0;
						res_trig_q <= 8'd0;
						state_q    <= (in_data.func == FUNC_RELEASE) ? S_REL0 : S_REQ0;
					end
				end
				S_REQ0: begin
					e_q <= free_head_q;
					if (free_head_q == NIL) begin
						res_status_q <= ST_POOL_FULL;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_REQ1;
					end
				end
				S_REQ1: begin
					free_head_q <= next_rd;
					if (avail_q != 8'd0) begin
						avail_q      <= avail_q - 8'd1;
						res_status_q <= ST_GRANTED;
						res_task_q   <= task_q;
						res_trig_q   <= trig_q;
						sel_waiter_q <= 1'b0;
					end else begin
						res_status_q <= ST_QUEUED;
						sel_waiter_q <= 1'b1;
					end
					cur_q   <= rd_ptr;
					prev_q  <= NIL;
					state_q <= (rd_ptr == NIL) ? S_LINK : S_WALK;
				end
				S_REL0: begin
					e_q <= holder_head_q;
					if (holder_head_q == NIL) begin
						res_status_q <= ST_BAD_RELEASE;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_REL1;
					end
				end
				S_REL1: begin
					holder_head_q <= next_rd;
					free_head_q   <= e_q;
					e_q           <= waiter_head_q;
					if (waiter_head_q == NIL) begin
						if (avail_q != 8'hFF) begin
							avail_q <= avail_q + 8'd1;
						end
						res_status_q <= ST_RETURNED;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_REL2;
					end
				end
				S_REL2: begin
					// top waiter leaves the wait list and is sorted into the holders
					waiter_head_q <= next_rd;
					pr_q          <= rec.prio;
					res_task_q    <= rec.task_id;
					res_trig_q    <= rec.trigger;
					res_status_q  <= ST_WAITER_GRANT;
					sel_waiter_q  <= 1'b0;
					cur_q         <= holder_head_q;
					prev_q        <= NIL;
					state_q       <= (holder_head_q == NIL) ? S_LINK : S_WALK;
				end
				S_WALK: begin
					// step past entries of equal or higher priority
					if (rec.prio >= pr_q) begin
						prev_q  <= cur_q;
						cur_q   <= next_rd;
						if (next_rd == NIL) begin
							state_q <= S_LINK;
						end
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (prev_q == NIL) begin
						if (sel_waiter_q) begin
							waiter_head_q <= e_q;
						end else begin
							holder_head_q <= e_q;
						end
						state_q <= S_FIN;
					end else begin
						state_q <= S_LINK2;
					end
				end
				S_LINK2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						out_q <= '{status: res_status_q, woken_task: res_task_q,
							woken_trigger: res_trig_q, free_count: avail_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for counting_semaphore_priority_queue
// depends on csp_pkg and the block's rtl; holds its own predictor of the holder and wait lists
module tb_top;
	import csp_pkg::*;

	localparam int POOL = 16;
	localparam int NIL  = POOL;
	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	counting_semaphore_priority_queue #(
		.POOL_ENTRIES(POOL)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// shadow of the semaphore state
	logic [7:0] ent_task [POOL];
	logic [7:0] ent_prio [POOL];
	logic [7:0] ent_trig [POOL];
	int         ent_next [POOL];
	int         holders_head;
	int         waiters_head;
	int         free_head;
	logic [7:0] avail;
	logic [7:0] cfg_max_res;
	logic [4:0] cfg_entries;

	in_item_t  queued_ops[$];
	out_item_t awaited_status[$];
	int        errors;
	int        sender_idle_pct;
	int        stall_pct;
	logic      in_taken;

	function automatic void rebuild_lists();
		int n;
		n = (cfg_entries > POOL) ? POOL : cfg_entries;
		for (int i = 0; i < POOL; i++) begin
			ent_task[i] = '0;
			ent_prio[i] = '0;
			ent_trig[i] = '0;
			ent_next[i] = (i + 1 < n) ? i + 1 : NIL;
		end
		holders_head = NIL;
		waiters_head = NIL;
		free_head = (n > 0) ? 0 : NIL;
		avail = cfg_max_res;
	endfunction

	// place e behind every entry of equal or higher priority, returns the new head
	function automatic int insert_by_priority(int head, int e);
		int prev_e;
		int cur;
		int steps;
		prev_e = NIL;
		cur = head;
		steps = 0;
		while (cur < NIL && ent_prio[cur] >= ent_prio[e] && steps < POOL) begin
			prev_e = cur;
			cur = ent_next[cur];
			steps++;
		end
		ent_next[e] = cur;
		if (prev_e == NIL)
			return e;
		ent_next[prev_e] = e;
		return head;
	endfunction

	function automatic out_item_t apply_semaphore_op(in_item_t op);
		out_item_t r;
		int e;
		r = '0;
		if (op.func == FUNC_REQUEST) begin
			e = free_head;
			if (e >= NIL) begin
				r.status = ST_POOL_FULL;
			end else begin
				free_head = ent_next[e];
				ent_task[e] = op.task_id;
				ent_prio[e] = op.priority_req;
				ent_trig[e] = op.trigger;
				if (avail > 0) begin
					avail = avail - 8'd1;
					holders_head = insert_by_priority(holders_head, e);
					r.status = ST_GRANTED;
					r.woken_task = op.task_id;
					r.woken_trigger = op.trigger;
				end else begin
					waiters_head = insert_by_priority(waiters_head, e);
					r.status = ST_QUEUED;
				end
			end
		end else begin
			e = holders_head;
			if (e >= NIL) begin
				r.status = ST_BAD_RELEASE;
			end else begin
				holders_head = ent_next[e];
				ent_next[e] = free_head;
				free_head = e;
				e = waiters_head;
				if (e >= NIL) begin
					if (avail != 8'd255)
						avail = avail + 8'd1;
					r.status = ST_RETURNED;
				end else begin
					waiters_head = ent_next[e];
					holders_head = insert_by_priority(holders_head, e);
					r.status = ST_WAITER_GRANT;
					r.woken_task = ent_task[e];
					r.woken_trigger = ent_trig[e];
				end
			end
		end
		r.free_count = avail;
		return r;
	endfunction

	task automatic note_mismatch(string field, int exp_v, int got_v);
		if (errors < 10)
			$display("%0t: %s expected %0d got %0d", $realtime, field, exp_v, got_v);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("counting_semaphore_priority_queue: mismatch");
		$finish;
	end

	// input driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (queued_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				in_data <= queued_ops.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin
		out_item_t want;
		in_taken <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			if (awaited_status.size() == 0) begin
				note_mismatch("unexpected item, status", -1, out_data.status);
			end else begin
				want = awaited_status.pop_front();
				if (out_data.status !== want.status)
					note_mismatch("status", want.status, out_data.status);
				if (out_data.woken_task !== want.woken_task)
					note_mismatch("woken_task", want.woken_task, out_data.woken_task);
				if (out_data.woken_trigger !== want.woken_trigger)
					note_mismatch("woken_trigger", want.woken_trigger, out_data.woken_trigger);
				if (out_data.free_count !== want.free_count)
					note_mismatch("free_count", want.free_count, out_data.free_count);
			end
		end
		if (in_valid && !in_stall)
			awaited_status.push_back(apply_semaphore_op(in_data));
	end

	task automatic push_op(logic func, int task_id, int prio, int trig);
		in_item_t op;
		op.func = func;
		op.task_id = 8'(task_id);
		op.priority_req = 8'(prio);
		op.trigger = 8'(trig);
		queued_ops.push_back(op);
	endtask

	task automatic drain();
		while (queued_ops.size() > 0 || in_valid || awaited_status.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAX_RESOURCES)
			cfg_max_res = value[7:0];
		else
			cfg_entries = value[4:0];
		rebuild_lists();
	endtask

	task automatic set_limits(int max_res, int entries);
		write_reg(REG_MAX_RESOURCES, 32'(max_res));
		write_reg(REG_ENTRIES_IN_USE, 32'(entries));
	endtask

	// bursts of requests and releases so both lists fill up and drain again
	task automatic queue_random_ops(int count);
		int made;
		int burst;
		logic func;
		int prio;
		made = 0;
		while (made < count) begin
			burst = $urandom_range(1, 12);
			func = ($urandom_range(0, 99) < 55) ? FUNC_REQUEST : FUNC_RELEASE;
			for (int i = 0; i < burst && made < count; i++) begin
				// narrow priorities often, to get ties
				if ($urandom_range(0, 99) < 40)
					prio = $urandom_range(0, 3);
				else
					prio = $urandom_range(0, 255);
				push_op(func, $urandom_range(0, 255), prio, $urandom_range(0, 255));
				made++;
			end
		end
	endtask

	initial begin
		int max_tab [8];
		int ent_tab [8];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		cfg_max_res = 8'd1;
		cfg_entries = 5'd16;
		rebuild_lists();
		max_tab = '{1, 3, 2, 255, 0, 5, 1, 6};
		ent_tab = '{16, 16, 4, 16, 3, 31, 1, 8};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: one resource, full pool
		push_op(FUNC_RELEASE, 0, 0, 0);
		push_op(FUNC_REQUEST, 0, 0, 0);
		push_op(FUNC_REQUEST, 255, 255, 255);
		push_op(FUNC_REQUEST, 1, 255, 7);
		push_op(FUNC_REQUEST, 2, 128, 9);
		repeat (5) push_op(FUNC_RELEASE, 255, 255, 255);
		drain();
		// no resources, tiny pool: waits, then pool full
		set_limits(0, 2);
		repeat (3) push_op(FUNC_REQUEST, 17, 40, 33);
		push_op(FUNC_RELEASE, 0, 0, 0);
		drain();
		// empty pool
		set_limits(255, 0);
		push_op(FUNC_REQUEST, 5, 5, 5);
		push_op(FUNC_RELEASE, 5, 5, 5);
		drain();
		// oversized entry count, free count back at its top
		set_limits(255, 20);
		push_op(FUNC_REQUEST, 8, 9, 10);
		push_op(FUNC_REQUEST, 11, 9, 12);
		push_op(FUNC_RELEASE, 0, 0, 0);
		push_op(FUNC_RELEASE, 0, 0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_limits(max_tab[p], ent_tab[p]);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 65;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 65;
				end
				default: begin
					sender_idle_pct = 34;
					stall_pct = 34;
				end
			endcase
			if (p == 2) begin
				// sender holds off until every result is back
				queue_random_ops(90);
				drain();
				queue_random_ops(90);
			end else begin
				queue_random_ops(180);
			end
			drain();
		end

		if (errors == 0 && awaited_status.size() == 0)
			$display("counting_semaphore_priority_queue: match");
		else
			$display("counting_semaphore_priority_queue: mismatch");
		$finish;
	end

endmodule
